// ----- hw/rtl/lbps_pkg.sv -----
package lbps_pkg;

  localparam int NUM_REGS     = 8;
  localparam int NUM_PATTERNS = 11;
  localparam int MAX_STEPS    = 19;
  localparam int DUR_W        = 24;
  localparam int TIME_W       = 32;
  localparam int SEL_W        = 4;
  localparam int POS_W        = 5;
  localparam int REG_IDX_W    = $clog2(NUM_REGS);
  localparam int ROW_W        = $clog2(NUM_PATTERNS);

  localparam logic [SEL_W-1:0] OFF_CODE          = SEL_W'(10);
  localparam logic [DUR_W-1:0] SEARCH_GAP_MS     = DUR_W'(900);
  localparam logic [3:0]       KIND_SEARCH       = 4'd8;

  // Duration kinds 0..7 name a configuration register
  localparam logic [3:0] KIND_TINY_FLASH  = 4'd0;
  localparam logic [3:0] KIND_TINY_GAP    = 4'd1;
  localparam logic [3:0] KIND_SHORT_FLASH = 4'd2;
  localparam logic [3:0] KIND_SHORT_GAP   = 4'd3;
  localparam logic [3:0] KIND_MED_FLASH   = 4'd4;
  localparam logic [3:0] KIND_MED_GAP     = 4'd5;
  localparam logic [3:0] KIND_LONG_FLASH  = 4'd6;
  localparam logic [3:0] KIND_SEPARATOR   = 4'd7;

  typedef logic [NUM_REGS-1:0][DUR_W-1:0] dur_set_t;

  typedef struct packed {
    logic       lvl;
    logic [3:0] kind;
  } step_t;

  typedef struct packed {
    logic             led_on;
    logic             led_changed;
    logic [POS_W-1:0] step_pos;
  } result_t;

  localparam dur_set_t CFG_RESET = {
    DUR_W'(2000), DUR_W'(800), DUR_W'(500), DUR_W'(500),
    DUR_W'(200),  DUR_W'(200), DUR_W'(100), DUR_W'(100)
  };

  localparam step_t TF  = '{lvl: 1'b1, kind: KIND_TINY_FLASH};
  localparam step_t TG  = '{lvl: 1'b0, kind: KIND_TINY_GAP};
  localparam step_t SF  = '{lvl: 1'b1, kind: KIND_SHORT_FLASH};
  localparam step_t SG  = '{lvl: 1'b0, kind: KIND_SHORT_GAP};
  localparam step_t MF  = '{lvl: 1'b1, kind: KIND_MED_FLASH};
  localparam step_t MG  = '{lvl: 1'b0, kind: KIND_MED_GAP};
  localparam step_t LF  = '{lvl: 1'b1, kind: KIND_LONG_FLASH};
  localparam step_t SPO = '{lvl: 1'b0, kind: KIND_SEPARATOR};
  localparam step_t SPN = '{lvl: 1'b1, kind: KIND_SEPARATOR};
  localparam step_t SRG = '{lvl: 1'b0, kind: KIND_SEARCH};

  localparam logic [POS_W-1:0] PAT_LEN [NUM_PATTERNS] = '{
    5'd2, 5'd2, 5'd2, 5'd1, 5'd6, 5'd2, 5'd11, 5'd13, 5'd9, 5'd19, 5'd1
  };

  // Entries past a pattern's length are never read
  localparam step_t PAT_TAB [NUM_PATTERNS][MAX_STEPS] = '{
    '{MF, MG, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO,
      SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO},
    '{TF, SRG, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO,
      SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO},
    '{LF, SG, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO,
      SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO},
    '{SPN, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO,
      SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO},
    '{LF, TG, TF, TG, TF, SPO, SPO, SPO, SPO, SPO,
      SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO},
    '{SF, SG, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO,
      SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO},
    '{SF, SG, SF, SG, SF, SG, TF, TG, TF, TG,
      SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO},
    '{SF, SG, SF, SG, SF, SG, TF, TG, TF, TG,
      TF, TG, SPO, SPO, SPO, SPO, SPO, SPO, SPO},
    '{SF, SG, SF, SG, SF, SG, TF, TG, SPO, SPO,
      SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO},
    '{SF, SG, SF, SG, SF, SG, LF, SG, LF, SG,
      LF, SG, SF, SG, SF, SG, SF, SG, SPO},
    '{SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO,
      SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO, SPO}
  };

  // Codes above the last pattern fall back to the off pattern
  function automatic logic [ROW_W-1:0] pat_row(input logic [SEL_W-1:0] code);
    logic [ROW_W-1:0] row;
    row = (code < SEL_W'(NUM_PATTERNS)) ? ROW_W'(code) : ROW_W'(OFF_CODE);
    return row;
  endfunction

  function automatic logic [DUR_W-1:0] step_dur(input step_t st, input dur_set_t durs);
    logic [DUR_W-1:0] d;
    d = (st.kind < 4'(NUM_REGS)) ? durs[st.kind[REG_IDX_W-1:0]] : SEARCH_GAP_MS;
    return d;
  endfunction

endpackage

// ----- hw/rtl/lbps_cfg_regs.sv -----
module lbps_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lbps_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [lbps_pkg::DUR_W-1:0]     cfg_wdata,
  output lbps_pkg::dur_set_t             durs
);
  import lbps_pkg::*;

  dur_set_t durs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      durs_r <= CFG_RESET;
    end else if (cfg_we) begin
      durs_r[cfg_index] <= cfg_wdata;
    end
  end

  assign durs = durs_r;

endmodule

// ----- hw/rtl/lbps_step_core.sv -----
module lbps_step_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [lbps_pkg::TIME_W-1:0] now,
  input  logic [lbps_pkg::SEL_W-1:0]  code,
  input  lbps_pkg::dur_set_t          durs,
  output lbps_pkg::result_t           res
);
  import lbps_pkg::*;

  logic [SEL_W-1:0]  prev_code_r, prev_code_nxt;
  logic [POS_W-1:0]  step_cnt_r,  step_cnt_nxt;
  logic [TIME_W-1:0] start_r,     start_nxt;
  logic              led_r,       led_nxt;

  logic [ROW_W-1:0]  row;
  logic [POS_W-1:0]  len;
  logic              restart;
  logic [POS_W-1:0]  cnt0;
  logic [POS_W:0]    cnt_inc;
  logic [TIME_W-1:0] start0;
  logic [TIME_W-1:0] elapsed;
  step_t             step0;
  step_t             step1;
  logic              adv;

  always_comb begin
    row     = pat_row(code);
    len     = PAT_LEN[row];
    restart = (code != prev_code_r);
    cnt0    = restart ? '0 : step_cnt_r;
    if (cnt0 >= len) begin
      cnt0 = '0;
    end
    start0  = restart ? now : start_r;
    step0   = PAT_TAB[row][cnt0];
    elapsed = now - start0;
    adv     = (elapsed >= TIME_W'(step_dur(step0, durs)));
    cnt_inc = {1'b0, cnt0} + (POS_W+1)'(1);

    step_cnt_nxt = cnt0;
    start_nxt    = start0;
    if (adv) begin
      // wrap to the first step after the last one
      step_cnt_nxt = (cnt_inc >= {1'b0, len}) ? '0 : cnt_inc[POS_W-1:0];
      start_nxt    = now;
    end
    step1         = PAT_TAB[row][step_cnt_nxt];
    led_nxt       = step1.lvl;
    prev_code_nxt = code;

    res.led_on      = led_nxt;
    res.led_changed = (led_nxt != led_r);
    res.step_pos    = step_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_code_r <= OFF_CODE;
      step_cnt_r  <= '0;
      start_r     <= '0;
      led_r       <= 1'b0;
    end else if (fire) begin
      prev_code_r <= prev_code_nxt;
      step_cnt_r  <= step_cnt_nxt;
      start_r     <= start_nxt;
      led_r       <= led_nxt;
    end
  end

endmodule

// ----- hw/rtl/led_blink_pattern_sequencer_unit.sv -----
// LED blink pattern sequencer. Each input transfer is one update tick with a
// millisecond timestamp and a pattern code; each tick gives exactly one result
// with the LED level, a changed flag and the step index in the active pattern.
// A tick is registered on entry, evaluated combinationally against the
// sequencer state and the pattern table, and held in an output register; a
// new tick is taken every cycle while the output side does not stall. Step
// durations come from eight 24-bit millisecond registers on the cfg port;
// write them only while idle.
module led_blink_pattern_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [39:0]                    in_tdata,   // current_time_ms, pattern_select, pad
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // led_on, led_changed, step_position, pad
  input  logic                           cfg_we,
  input  logic [lbps_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [lbps_pkg::DUR_W-1:0]     cfg_wdata
);
  import lbps_pkg::*;

  logic              in_vld_r;
  logic [TIME_W-1:0] in_time_r;
  logic [SEL_W-1:0]  in_sel_r;
  logic              out_vld_r;
  result_t           out_res_r;
  logic              advance;
  logic              fire;
  dur_set_t          durs;
  result_t           res;

  assign advance   = !out_vld_r || out_tready;
  assign fire      = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;

  lbps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .durs      (durs)
  );

  lbps_step_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .now   (in_time_r),
    .code  (in_sel_r),
    .durs  (durs),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_time_r <= in_tdata[TIME_W-1:0];
      in_sel_r  <= in_tdata[TIME_W+SEL_W-1:TIME_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  // hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_res_r.step_pos, out_res_r.led_changed, out_res_r.led_on};

  a_tick_enters : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> in_vld_r)
    else $error("accepted tick not held in input register");

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("evaluated tick did not produce a result");

  a_pos_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_res_r.step_pos < POS_W'(MAX_STEPS)))
    else $error("step index beyond longest pattern");

  a_stall_holds_input : assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> (in_vld_r && $stable(in_time_r) && $stable(in_sel_r)))
    else $error("stalled tick lost from input register");

endmodule

// ----- verif/tb_led_blink_pattern_sequencer_unit.sv -----
package tb_blink_pkg;

  typedef enum logic [3:0] {
    PAT_BOOT, PAT_SEARCHING, PAT_CONNECTED, PAT_CLIENT, PAT_AP, PAT_OTA,
    PAT_AUTH, PAT_RECOVERABLE, PAT_NTP, PAT_FATAL, PAT_OFF,
    PAT_OFF_B, PAT_OFF_C, PAT_OFF_D, PAT_OFF_E, PAT_OFF_F
  } pattern_code_t;

  typedef enum logic [2:0] {
    REG_TINY_FLASH, REG_TINY_GAP, REG_SHORT_FLASH, REG_SHORT_GAP,
    REG_MED_FLASH, REG_MED_GAP, REG_LONG_FLASH, REG_SEPARATOR
  } dur_reg_t;

  typedef enum logic [3:0] {
    DK_TINY_FLASH, DK_TINY_GAP, DK_SHORT_FLASH, DK_SHORT_GAP,
    DK_MED_FLASH, DK_MED_GAP, DK_LONG_FLASH, DK_SEPARATOR, DK_SEARCH
  } dur_kind_t;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    logic       led_on;
    logic       led_changed;
    logic [4:0] step_pos;
  } blink_result_t;

  localparam logic [23:0] SEARCH_GAP_LEN = 24'd900;
  localparam logic [23:0] DUR_DEFAULT [8] = '{
    24'd100, 24'd100, 24'd200, 24'd200, 24'd500, 24'd500, 24'd800, 24'd2000
  };

  // step word: LED level on top, duration kind below
  localparam logic [4:0] ST_TF  = {1'b1, DK_TINY_FLASH};
  localparam logic [4:0] ST_TG  = {1'b0, DK_TINY_GAP};
  localparam logic [4:0] ST_SF  = {1'b1, DK_SHORT_FLASH};
  localparam logic [4:0] ST_SG  = {1'b0, DK_SHORT_GAP};
  localparam logic [4:0] ST_MF  = {1'b1, DK_MED_FLASH};
  localparam logic [4:0] ST_MG  = {1'b0, DK_MED_GAP};
  localparam logic [4:0] ST_LF  = {1'b1, DK_LONG_FLASH};
  localparam logic [4:0] ST_SPO = {1'b0, DK_SEPARATOR};
  localparam logic [4:0] ST_SPN = {1'b1, DK_SEPARATOR};
  localparam logic [4:0] ST_SRG = {1'b0, DK_SEARCH};

  localparam int BLINK_LEN [11] = '{2, 2, 2, 1, 6, 2, 11, 13, 9, 19, 1};

  localparam logic [4:0] BLINK_STEPS [11][19] = '{
    '{ST_MF, ST_MG, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO,
      ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO},
    '{ST_TF, ST_SRG, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO,
      ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO},
    '{ST_LF, ST_SG, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO,
      ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO},
    '{ST_SPN, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO,
      ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO},
    '{ST_LF, ST_TG, ST_TF, ST_TG, ST_TF, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO,
      ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO},
    '{ST_SF, ST_SG, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO,
      ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO},
    '{ST_SF, ST_SG, ST_SF, ST_SG, ST_SF, ST_SG, ST_TF, ST_TG, ST_TF, ST_TG,
      ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO},
    '{ST_SF, ST_SG, ST_SF, ST_SG, ST_SF, ST_SG, ST_TF, ST_TG, ST_TF, ST_TG,
      ST_TF, ST_TG, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO},
    '{ST_SF, ST_SG, ST_SF, ST_SG, ST_SF, ST_SG, ST_TF, ST_TG, ST_SPO, ST_SPO,
      ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO},
    '{ST_SF, ST_SG, ST_SF, ST_SG, ST_SF, ST_SG, ST_LF, ST_SG, ST_LF, ST_SG,
      ST_LF, ST_SG, ST_SF, ST_SG, ST_SF, ST_SG, ST_SF, ST_SG, ST_SPO},
    '{ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO,
      ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO, ST_SPO}
  };

  class blink_scoreboard;
    logic [23:0]   dur_ms [8];
    logic [3:0]    last_code;
    logic [4:0]    step_idx;
    logic [31:0]   step_t0;
    logic          level;
    blink_result_t pending_results [$];
    int            errors;
    int            ticks;
    int            checked;
    int            toggles;

    function new();
      foreach (dur_ms[i]) dur_ms[i] = DUR_DEFAULT[i];
      last_code = PAT_OFF;
      step_idx  = '0;
      step_t0   = '0;
      level     = 1'b0;
      errors    = 0;
      ticks     = 0;
      checked   = 0;
      toggles   = 0;
    endfunction

    function void set_duration(int idx, logic [23:0] value);
      dur_ms[idx] = value;
    endfunction

    function logic [23:0] step_length(logic [4:0] st);
      if (st[3:0] == DK_SEARCH) return SEARCH_GAP_LEN;
      return dur_ms[st[2:0]];
    endfunction

    function void note_tick(logic [31:0] now, logic [3:0] code);
      int            row;
      int            len;
      logic [4:0]    st;
      logic [31:0]   elapsed;
      logic          prior;
      blink_result_t res;
      prior = level;
      row   = (code >= PAT_OFF_B) ? int'(PAT_OFF) : int'(code);
      len   = BLINK_LEN[row];
      // a new code restarts the list and the timer
      if (code != last_code) begin
        step_idx  = '0;
        step_t0   = now;
        last_code = code;
      end
      if (step_idx >= len) step_idx = '0;
      st      = BLINK_STEPS[row][step_idx];
      elapsed = now - step_t0;
      if (elapsed >= {8'd0, step_length(st)}) begin
        step_idx = step_idx + 5'd1;
        if (step_idx >= len) step_idx = '0;
        step_t0 = now;
        st      = BLINK_STEPS[row][step_idx];
      end
      level           = st[4];
      res.led_on      = level;
      res.led_changed = (level != prior);
      res.step_pos    = step_idx;
      pending_results.push_back(res);
      ticks++;
    endfunction

    function void check_result(logic [7:0] data);
      blink_result_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got 0x%02h", $time, data);
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      checked++;
      if (data[1]) toggles++;
      if (data[0] !== exp_res.led_on) begin
        $display("%0t: led_on mismatch, expected %0d, got %0d",
                 $time, exp_res.led_on, data[0]);
        errors++;
      end
      if (data[1] !== exp_res.led_changed) begin
        $display("%0t: led_changed mismatch, expected %0d, got %0d",
                 $time, exp_res.led_changed, data[1]);
        errors++;
      end
      if (data[6:2] !== exp_res.step_pos) begin
        $display("%0t: step_position mismatch, expected %0d, got %0d",
                 $time, exp_res.step_pos, data[6:2]);
        errors++;
      end
    endfunction
  endclass

endpackage

module tb_led_blink_pattern_sequencer_unit;
  import tb_blink_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_TICKS = 180;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        cfg_we;
  logic [lbps_pkg::REG_IDX_W-1:0] cfg_index;
  logic [lbps_pkg::DUR_W-1:0]     cfg_wdata;

  blink_scoreboard sb;
  int              cycle_count;
  int              burst_left;
  bit              hold_off_req;
  bit              hold_off_done;

  led_blink_pattern_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver: windows of random stall behavior, plus one long hold-off on request
  initial begin
    int unsigned window;
    rx_mode_t    mode;
    window        = 0;
    mode          = RX_ALWAYS;
    hold_off_done = 1'b0;
    out_tready    <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_tready    <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (window == 0) begin
        window = $urandom_range(16, 96);
        mode   = rx_mode_t'($urandom_range(0, 3));
      end
      window--;
      case (mode)
        RX_ALWAYS:   out_tready <= 1'b1;
        RX_MOSTLY:   out_tready <= ($urandom_range(0, 3) != 0);
        RX_RARELY:   out_tready <= ($urandom_range(0, 3) == 0);
        default:     out_tready <= (cycle_count[1:0] == 2'd0);
      endcase
    end
  end

  task automatic send_tick(input logic [31:0] now, input logic [3:0] code);
    int gap;
    in_tdata  <= {4'd0, code, now};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_tick(now, code);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_duration(input dur_reg_t idx, input logic [23:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_duration(int'(idx), value);
  endtask

  task automatic run_phase(input int phase, input logic [31:0] span);
    logic [31:0] now;
    logic [3:0]  code;
    int          sent;
    int          run_len;
    int          roll;
    now  = (phase == 3) ? 32'hFFFF_FF00 : $urandom;
    sent = 0;
    while (sent < PHASE_TICKS) begin
      run_len = $urandom_range(4, 50);
      roll    = $urandom_range(0, 99);
      if (roll < 10) begin
        // noise: arbitrary timestamps and codes
        run_len = $urandom_range(1, 4);
        repeat (run_len) send_tick($urandom, 4'($urandom_range(0, 15)));
      end else begin
        code = (roll < 85) ? 4'($urandom_range(0, 9)) : 4'($urandom_range(10, 15));
        repeat (run_len) begin
          if ($urandom_range(0, 29) == 0) now = now - $urandom_range(1, span);
          else now = now + $urandom_range(0, span);
          send_tick(now, code);
        end
      end
      sent += run_len;
    end
  endtask

  initial begin
    logic [23:0] value;
    logic [31:0] span;
    sb            = new();
    cycle_count   = 0;
    burst_left    = 1;
    hold_off_req  = 1'b0;
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_TINY_FLASH;
    cfg_wdata     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: off code held, full-range wrap, every code, searching gap edges
    send_tick(32'd0, PAT_OFF);
    send_tick(32'hFFFF_FFFF, PAT_OFF);
    for (int k = 0; k < 16; k++) send_tick(32'(1000 + 3000 * k), 4'(k));
    send_tick(32'd60000, PAT_SEARCHING);
    send_tick(32'd60100, PAT_SEARCHING);
    send_tick(32'd61000, PAT_SEARCHING);
    send_tick(32'd60999, PAT_SEARCHING);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        for (int r = 0; r < 8; r++) begin
          case (p)
            1:       value = 24'd0;
            2:       value = 24'hFF_FFFF;
            5:       value = 24'($urandom);
            7:       value = ($urandom_range(0, 1) == 0) ? 24'd0 : 24'($urandom_range(1, 8));
            9:       value = 24'($urandom_range(50, 300));
            default: value = 24'($urandom_range(0, 40));
          endcase
          write_duration(dur_reg_t'(r), value);
        end
        cfg_we <= 1'b0;
      end
      case (p)
        0:       span = 32'd300;
        1:       span = 32'd3;
        2, 5:    span = 32'h007F_FFFF;
        9:       span = 32'd100;
        default: span = 32'd15;
      endcase
      // hold off the receiver while this phase keeps the input busy
      if (p == 4) hold_off_req = 1'b1;
      run_phase(p, span);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0 outstanding",
               $time, sb.pending_results.size());
      sb.errors++;
    end
    $display("Sent %0d ticks over %0d duration settings, all 16 pattern codes,", sb.ticks,
             NUM_PHASES);
    $display("zero and full-scale durations; %0d results checked, %0d LED toggles",
             sb.checked, sb.toggles);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lbps_pkg.sv
hw/rtl/lbps_cfg_regs.sv
hw/rtl/lbps_step_core.sv
hw/rtl/led_blink_pattern_sequencer_unit.sv
verif/tb_led_blink_pattern_sequencer_unit.sv
